[hdl/qibm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qibm_pkg
// Shared widths, constants and register codes of the inverse bilinear mapper.
// ----------------------------------------------------------------------------
package qibm_pkg;

	localparam int COORD_WIDTH_DEF = 32;

	localparam int LOC_W     = 32;
	localparam int LOC_FRAC  = 28;
	localparam int ITER_W    = 7;
	localparam int TOL_W     = 29;
	localparam int COEF_BITS = 25;

	localparam int MUL_W = 36;
	localparam int DET_W = 64;
	localparam int NUM_W = 96;
	localparam int QUO_W = 34;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = TOL_W;

	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd1;

	localparam logic [TOL_W-1:0]  TOL_RESET   = 29'd1;
	localparam logic [ITER_W-1:0] ITER_CAP    = 7'd100;
	localparam logic [ITER_W-1:0] MAXIT_RESET = 7'd100;

	localparam logic signed [LOC_W-1:0] LOC_ONE  = 32'sh1000_0000;
	localparam logic signed [LOC_W-1:0] LOC_MONE = -32'sh1000_0000;

endpackage : qibm_pkg
`default_nettype wire

[hdl/quad_inverse_bilinear_map_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// quad_inverse_bilinear_map_top
// Newton inverse bilinear mapping of a point into a quadrilateral.
//
// Input channel (in_valid/in_stall) carries four corners and a query point;
// a transfer happens when in_valid is high and in_stall low. in_stall is high
// while an item is being worked on. Output channel (out_valid/out_stall)
// carries xi, eta (Q3.28), inside_res, converged and iterations_used; a
// finished result waits in the output register while out_stall is high, and
// the next item may be taken meanwhile.
// A corner hit skips the Newton loop and goes straight to loading the output
// register. Otherwise coefficient normalization shifts the coefficients right
// by up to COORD_WIDTH-21 bits, then each Newton step runs 21 products on the
// shared multiplier, two divisions of 96 bit-serial steps each and one update;
// a singular step ends after its products. The output register is loaded
// next, which waits while a stalled result is still held. The next item is
// taken only once the current result has gone into the output register.
// Reset clears the state machine and output valid, sets tolerance to 1 and
// max_iterations to 100.
// ----------------------------------------------------------------------------
module quad_inverse_bilinear_map_top #(
	parameter int COORD_WIDTH = qibm_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [COORD_WIDTH-1:0]          corner0_x,
	input  wire logic signed [COORD_WIDTH-1:0]          corner0_y,
	input  wire logic signed [COORD_WIDTH-1:0]          corner1_x,
	input  wire logic signed [COORD_WIDTH-1:0]          corner1_y,
	input  wire logic signed [COORD_WIDTH-1:0]          corner2_x,
	input  wire logic signed [COORD_WIDTH-1:0]          corner2_y,
	input  wire logic signed [COORD_WIDTH-1:0]          corner3_x,
	input  wire logic signed [COORD_WIDTH-1:0]          corner3_y,
	input  wire logic signed [COORD_WIDTH-1:0]          point_x,
	input  wire logic signed [COORD_WIDTH-1:0]          point_y,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [qibm_pkg::LOC_W-1:0]           xi,
	output logic signed [qibm_pkg::LOC_W-1:0]           eta,
	output logic                                        inside_res,
	output logic                                        converged,
	output logic [qibm_pkg::ITER_W-1:0]                 iterations_used,
	input  wire logic                                   cfg_we,
	input  wire logic [qibm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [qibm_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int CFW   = COORD_WIDTH + 4;
	localparam int CB    = qibm_pkg::COEF_BITS;
	localparam int MW    = qibm_pkg::MUL_W;
	localparam int DW    = qibm_pkg::DET_W;
	localparam int NW    = qibm_pkg::NUM_W;
	localparam int QW    = qibm_pkg::QUO_W;
	localparam int LW    = qibm_pkg::LOC_W;
	localparam int IW    = qibm_pkg::ITER_W;
	localparam int TW    = qibm_pkg::TOL_W;
	localparam int FR    = qibm_pkg::LOC_FRAC;

	localparam logic [4:0] OP_PE   = 5'd0;
	localparam logic [4:0] OP_J00  = 5'd1;
	localparam logic [4:0] OP_J01  = 5'd2;
	localparam logic [4:0] OP_J10  = 5'd3;
	localparam logic [4:0] OP_J11  = 5'd4;
	localparam logic [4:0] OP_F0A  = 5'd5;
	localparam logic [4:0] OP_F0B  = 5'd6;
	localparam logic [4:0] OP_F0C  = 5'd7;
	localparam logic [4:0] OP_F1A  = 5'd8;
	localparam logic [4:0] OP_F1B  = 5'd9;
	localparam logic [4:0] OP_F1C  = 5'd10;
	localparam logic [4:0] OP_DTA  = 5'd11;
	localparam logic [4:0] OP_DTB  = 5'd12;
	localparam logic [4:0] OP_N0A  = 5'd13;
	localparam logic [4:0] OP_N0B  = 5'd14;
	localparam logic [4:0] OP_N0C  = 5'd15;
	localparam logic [4:0] OP_N0D  = 5'd16;
	localparam logic [4:0] OP_N1A  = 5'd17;
	localparam logic [4:0] OP_N1B  = 5'd18;
	localparam logic [4:0] OP_N1C  = 5'd19;
	localparam logic [4:0] OP_N1D  = 5'd20;

	typedef enum logic [3:0] {
		S_IDLE, S_NORM, S_MUL, S_ACC, S_DST0, S_DW0, S_DST1, S_DW1, S_UPD, S_FIN
	} state_t;

	state_t state_q;

	logic [TW-1:0]  tol_q;
	logic [IW-1:0]  maxit_q;
	logic [IW-1:0]  niter;

	logic signed [COORD_WIDTH-1:0] cx [0:3];
	logic signed [COORD_WIDTH-1:0] cy [0:3];
	logic signed [CFW-1:0] ex [0:3];
	logic signed [CFW-1:0] ey [0:3];
	logic signed [CFW-1:0] ox, oy;
	logic signed [CFW-1:0] cf_in [0:7];
	logic [CFW-1:0]        m_in;
	logic                  hit;
	logic signed [LW-1:0]  hit_xi, hit_eta;

	logic signed [CFW-1:0] cf_q [0:7];
	logic [CFW-1:0]        m_q;
	logic [4:0]            op_q;
	logic signed [LW-1:0]  xi_q, eta_q;
	logic signed [MW-1:0]  pe_q;
	logic signed [LW-1:0]  j00_q, j01_q, j10_q, j11_q;
	logic signed [DW-1:0]  f0_q, f1_q, det_q;
	logic signed [NW-1:0]  n0_q, n1_q;
	logic signed [QW-1:0]  dx_q, de_q;
	logic                  conv_q;
	logic [IW-1:0]         used_q;

	logic signed [MW-1:0]   mul_a, mul_b;
	logic signed [2*MW-1:0] mul_p;
	logic signed [DW-1:0]   p64, pfl;
	logic signed [NW-1:0]   p96, p96h;

	logic                  div_start;
	logic                  div_done;
	logic signed [QW-1:0]  div_quo;
	logic signed [NW-1:0]  div_num;
	logic [QW-1:0]         dx_mag, de_mag;
	logic                  tol_hit;

	function automatic logic signed [MW-1:0] cfm(input logic signed [CFW-1:0] v);
		return MW'($signed(v[CB:0]));
	endfunction

	function automatic logic signed [DW-1:0] cfd(input logic signed [CFW-1:0] v);
		return DW'($signed(v[CB:0]));
	endfunction

	function automatic logic signed [MW-1:0] l2m(input logic signed [LW-1:0] v);
		return MW'(v);
	endfunction

	function automatic logic signed [MW-1:0] fhi(input logic signed [DW-1:0] v);
		return MW'($signed(v[DW-1:32]));
	endfunction

	function automatic logic signed [MW-1:0] flo(input logic signed [DW-1:0] v);
		return $signed({{(MW-32){1'b0}}, v[31:0]});
	endfunction

	function automatic logic [CFW-1:0] magc(input logic signed [CFW-1:0] v);
		return v[CFW-1] ? CFW'(-v) : CFW'(v);
	endfunction

	function automatic logic signed [LW-1:0] sat_add(input logic signed [LW-1:0] a,
			input logic signed [QW-1:0] d);
		logic signed [QW:0] s;
		s = (QW+1)'(a) + (QW+1)'(d);
		if (s > (QW+1)'(32'sh7FFF_FFFF))
			return 32'sh7FFF_FFFF;
		else if (s < -(QW+1)'(33'sh0_8000_0000))
			return -32'sh8000_0000;
		else
			return s[LW-1:0];
	endfunction

	assign cx[0] = corner0_x;
	assign cx[1] = corner1_x;
	assign cx[2] = corner2_x;
	assign cx[3] = corner3_x;
	assign cy[0] = corner0_y;
	assign cy[1] = corner1_y;
	assign cy[2] = corner2_y;
	assign cy[3] = corner3_y;

	assign in_stall = state_q != S_IDLE;
	assign niter    = (maxit_q > qibm_pkg::ITER_CAP) ? qibm_pkg::ITER_CAP : maxit_q;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ex[k] = CFW'(cx[k]);
			ey[k] = CFW'(cy[k]);
		end
		ox = CFW'(point_x);
		oy = CFW'(point_y);
		cf_in[0] = ex[0] + ex[1] + ex[2] + ex[3] - (ox <<< 2);
		cf_in[1] = -ex[0] + ex[1] + ex[2] - ex[3];
		cf_in[2] = -ex[0] - ex[1] + ex[2] + ex[3];
		cf_in[3] = ex[0] - ex[1] + ex[2] - ex[3];
		cf_in[4] = ey[0] + ey[1] + ey[2] + ey[3] - (oy <<< 2);
		cf_in[5] = -ey[0] + ey[1] + ey[2] - ey[3];
		cf_in[6] = -ey[0] - ey[1] + ey[2] + ey[3];
		cf_in[7] = ey[0] - ey[1] + ey[2] - ey[3];
		m_in = '0;
		for (int k = 0; k < 8; k++)
			m_in = m_in | magc(cf_in[k]);

		hit     = 1'b0;
		hit_xi  = qibm_pkg::LOC_ONE;
		hit_eta = qibm_pkg::LOC_ONE;
		for (int k = 3; k >= 0; k--) begin
			if (cx[k] == point_x && cy[k] == point_y) begin
				hit     = 1'b1;
				hit_xi  = (k == 0 || k == 3) ? qibm_pkg::LOC_MONE : qibm_pkg::LOC_ONE;
				hit_eta = (k == 0 || k == 1) ? qibm_pkg::LOC_MONE : qibm_pkg::LOC_ONE;
			end
		end
	end

	always_comb begin
		case (op_q)
			OP_PE:   begin mul_a = l2m(xi_q);     mul_b = l2m(eta_q);    end
			OP_J00:  begin mul_a = cfm(cf_q[3]);  mul_b = l2m(eta_q);    end
			OP_J01:  begin mul_a = cfm(cf_q[3]);  mul_b = l2m(xi_q);     end
			OP_J10:  begin mul_a = cfm(cf_q[7]);  mul_b = l2m(eta_q);    end
			OP_J11:  begin mul_a = cfm(cf_q[7]);  mul_b = l2m(xi_q);     end
			OP_F0A:  begin mul_a = cfm(cf_q[1]);  mul_b = l2m(xi_q);     end
			OP_F0B:  begin mul_a = cfm(cf_q[2]);  mul_b = l2m(eta_q);    end
			OP_F0C:  begin mul_a = cfm(cf_q[3]);  mul_b = pe_q;          end
			OP_F1A:  begin mul_a = cfm(cf_q[5]);  mul_b = l2m(xi_q);     end
			OP_F1B:  begin mul_a = cfm(cf_q[6]);  mul_b = l2m(eta_q);    end
			OP_F1C:  begin mul_a = cfm(cf_q[7]);  mul_b = pe_q;          end
			OP_DTA:  begin mul_a = l2m(j00_q);    mul_b = l2m(j11_q);    end
			OP_DTB:  begin mul_a = l2m(j01_q);    mul_b = l2m(j10_q);    end
			OP_N0A:  begin mul_a = l2m(j01_q);    mul_b = fhi(f1_q);     end
			OP_N0B:  begin mul_a = l2m(j01_q);    mul_b = flo(f1_q);     end
			OP_N0C:  begin mul_a = l2m(j11_q);    mul_b = fhi(f0_q);     end
			OP_N0D:  begin mul_a = l2m(j11_q);    mul_b = flo(f0_q);     end
			OP_N1A:  begin mul_a = l2m(j10_q);    mul_b = fhi(f0_q);     end
			OP_N1B:  begin mul_a = l2m(j10_q);    mul_b = flo(f0_q);     end
			OP_N1C:  begin mul_a = l2m(j00_q);    mul_b = fhi(f1_q);     end
			OP_N1D:  begin mul_a = l2m(j00_q);    mul_b = flo(f1_q);     end
			default: begin mul_a = '0;            mul_b = '0;            end
		endcase
	end

	qibm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	always_comb begin
		p64  = mul_p[DW-1:0];
		pfl  = p64 >>> FR;
		p96  = NW'(p64);
		p96h = p96 <<< 32;
	end

	assign div_start = (state_q == S_DST0) || (state_q == S_DST1);
	assign div_num   = (state_q == S_DST0) ? n0_q : n1_q;

	qibm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (det_q),
		.done_q (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		dx_mag  = dx_q[QW-1] ? QW'(-dx_q) : QW'(dx_q);
		de_mag  = de_q[QW-1] ? QW'(-de_q) : QW'(de_q);
		tol_hit = (dx_mag < QW'(tol_q)) && (de_mag < QW'(tol_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			tol_q     <= qibm_pkg::TOL_RESET;
			maxit_q   <= qibm_pkg::MAXIT_RESET;
			op_q      <= OP_PE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					qibm_pkg::CFG_TOLERANCE: tol_q   <= cfg_data;
					qibm_pkg::CFG_MAX_ITER:  maxit_q <= cfg_data[IW-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall && state_q != S_FIN)
				out_valid <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						used_q <= '0;
						if (hit) begin
							xi_q    <= hit_xi;
							eta_q   <= hit_eta;
							conv_q  <= 1'b1;
							state_q <= S_FIN;
						end else begin
							for (int k = 0; k < 8; k++)
								cf_q[k] <= cf_in[k];
							m_q     <= m_in;
							xi_q    <= '0;
							eta_q   <= '0;
							conv_q  <= 1'b0;
							state_q <= S_NORM;
						end
					end
				end
				S_NORM: begin
					if (|m_q[CFW-1:CB]) begin
						m_q <= m_q >> 1;
						for (int k = 0; k < 8; k++)
							cf_q[k] <= cf_q[k] >>> 1;
					end else if (niter == '0) begin
						state_q <= S_FIN;
					end else begin
						op_q    <= OP_PE;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					case (op_q)
						OP_PE:   pe_q  <= pfl[MW-1:0];
						OP_J00:  j00_q <= LW'(cfd(cf_q[1]) + pfl);
						OP_J01:  j01_q <= LW'(cfd(cf_q[2]) + pfl);
						OP_J10:  j10_q <= LW'(cfd(cf_q[5]) + pfl);
						OP_J11:  j11_q <= LW'(cfd(cf_q[6]) + pfl);
						OP_F0A:  f0_q  <= (cfd(cf_q[0]) <<< FR) + p64;
						OP_F0B:  f0_q  <= f0_q + p64;
						OP_F0C:  f0_q  <= f0_q + p64;
						OP_F1A:  f1_q  <= (cfd(cf_q[4]) <<< FR) + p64;
						OP_F1B:  f1_q  <= f1_q + p64;
						OP_F1C:  f1_q  <= f1_q + p64;
						OP_DTA:  det_q <= p64;
						OP_DTB:  det_q <= det_q - p64;
						OP_N0A:  n0_q  <= p96h;
						OP_N0B:  n0_q  <= n0_q + p96;
						OP_N0C:  n0_q  <= n0_q - p96h;
						OP_N0D:  n0_q  <= n0_q - p96;
						OP_N1A:  n1_q  <= p96h;
						OP_N1B:  n1_q  <= n1_q + p96;
						OP_N1C:  n1_q  <= n1_q - p96h;
						OP_N1D:  n1_q  <= n1_q - p96;
						default: ;
					endcase
					if (op_q == OP_N1D) begin
						used_q  <= used_q + 1'b1;
						state_q <= (det_q == '0) ? S_FIN : S_DST0;
					end else begin
						op_q    <= op_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_DST0: state_q <= S_DW0;
				S_DW0: begin
					if (div_done) begin
						dx_q    <= div_quo;
						state_q <= S_DST1;
					end
				end
				S_DST1: state_q <= S_DW1;
				S_DW1: begin
					if (div_done) begin
						de_q    <= div_quo;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (tol_hit) begin
						conv_q  <= 1'b1;
						state_q <= S_FIN;
					end else begin
						xi_q  <= sat_add(xi_q, dx_q);
						eta_q <= sat_add(eta_q, de_q);
						if (used_q < niter) begin
							op_q    <= OP_PE;
							state_q <= S_MUL;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (!out_valid || !out_stall) begin
						xi              <= xi_q;
						eta             <= eta_q;
						inside_res      <= xi_q >= qibm_pkg::LOC_MONE && xi_q <= qibm_pkg::LOC_ONE
							&& eta_q >= qibm_pkg::LOC_MONE && eta_q <= qibm_pkg::LOC_ONE;
						converged       <= conv_q;
						iterations_used <= used_q;
						out_valid       <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule : quad_inverse_bilinear_map_top
`default_nettype wire

[hdl/qibm_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qibm_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module qibm_mul (
	input  wire logic                                  clk,
	input  wire logic signed [qibm_pkg::MUL_W-1:0]     a,
	input  wire logic signed [qibm_pkg::MUL_W-1:0]     b,
	output logic signed [2*qibm_pkg::MUL_W-1:0]        p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule : qibm_mul
`default_nettype wire

[hdl/qibm_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qibm_div
// Bit-serial signed divider, truncating, quotient magnitude capped at 2^32.
// ----------------------------------------------------------------------------
module qibm_div (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic signed [qibm_pkg::NUM_W-1:0]     num,
	input  wire logic signed [qibm_pkg::DET_W-1:0]     den,
	output logic                                       done_q,
	output logic signed [qibm_pkg::QUO_W-1:0]          quo
);

	localparam int NW  = qibm_pkg::NUM_W;
	localparam int DW  = qibm_pkg::DET_W;
	localparam int QW  = qibm_pkg::QUO_W;
	localparam int CNT_W = $clog2(NW + 1);
	localparam logic [QW-1:0] CAP = QW'(1) << (QW - 2);

	logic [NW-1:0]    n_q;
	logic [DW-1:0]    d_q;
	logic [DW-1:0]    rem_q;
	logic [QW-2:0]    q_q;
	logic             neg_q;
	logic             run_q;
	logic [CNT_W-1:0] cnt_q;

	logic [DW:0]      rem_sh;
	logic             ge;
	logic [DW:0]      rem_n;
	logic [QW-1:0]    q_sh;
	logic [QW-1:0]    q_n;

	always_comb begin
		rem_sh = {rem_q, n_q[NW-1]};
		ge     = rem_sh >= {1'b0, d_q};
		rem_n  = ge ? rem_sh - {1'b0, d_q} : rem_sh;
		q_sh   = {q_q, ge};
		q_n    = (q_sh > CAP) ? CAP : q_sh;
		quo    = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				n_q   <= num[NW-1] ? NW'(-num) : NW'(num);
				d_q   <= den[DW-1] ? DW'(-den) : DW'(den);
				neg_q <= num[NW-1] != den[DW-1];
				rem_q <= '0;
				q_q   <= '0;
				cnt_q <= CNT_W'(NW);
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= rem_n[DW-1:0];
				q_q   <= q_n[QW-2:0];
				n_q   <= n_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule : qibm_div
`default_nettype wire

[tb/sv/tb_quad_inverse_bilinear_map_top.sv]
// ----------------------------------------------------------------------------
// tb_quad_inverse_bilinear_map_top
// Self-checking bench for the inverse bilinear mapper. A directed table covers
// corner hits, singular and extreme quads and register corners; random phases
// follow, mostly well-formed quads with some noise. Every output transfer is
// checked field by field against a fixed table result or an in-bench Newton predictor.
// ----------------------------------------------------------------------------
module tb_quad_inverse_bilinear_map_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [qibm_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [qibm_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam logic signed [31:0] U = 32'sh0001_0000;
	localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] SMIN = 32'sh8000_0000;

	typedef logic [9:0][31:0] quad_t;

	typedef struct packed {
		logic signed [31:0] xi;
		logic signed [31:0] eta;
		logic               ins;
		logic               conv;
		logic [6:0]         iters;
	} map_res_t;

	typedef struct {
		logic [qibm_pkg::TOL_W-1:0] tol;
		logic [6:0]                 maxit;
		quad_t                      f;
		bit                         typed;
		map_res_t                   res;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] corner0_x = '0, corner0_y = '0, corner1_x = '0, corner1_y = '0;
	logic signed [31:0] corner2_x = '0, corner2_y = '0, corner3_x = '0, corner3_y = '0;
	logic signed [31:0] point_x = '0, point_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] xi, eta;
	logic inside_res, converged;
	logic [6:0] iterations_used;
	logic cfg_we = 1'b0;
	logic [qibm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [qibm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [qibm_pkg::TOL_W-1:0] tol_q = qibm_pkg::TOL_RESET;
	logic [6:0] maxit_q = qibm_pkg::MAXIT_RESET;
	map_res_t pending_q[$];
	int errors = 0;
	longint cycles = 0;
	bit quiet = 1'b0;
	int stall_cnt = 0;
	vec_t dir_tab[$];

	quad_inverse_bilinear_map_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.corner0_x(corner0_x), .corner0_y(corner0_y),
		.corner1_x(corner1_x), .corner1_y(corner1_y),
		.corner2_x(corner2_x), .corner2_y(corner2_y),
		.corner3_x(corner3_x), .corner3_y(corner3_y),
		.point_x(point_x), .point_y(point_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.xi(xi), .eta(eta), .inside_res(inside_res), .converged(converged),
		.iterations_used(iterations_used),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic longint step_quot(logic signed [127:0] num, longint d);
		logic [127:0] un, ud, q;
		bit neg;
		neg = num[127] ^ (d < 0);
		un = num[127] ? -num : num;
		ud = (d < 0) ? 128'(-d) : 128'(d);
		q = un / ud;
		if (q > 128'h1_0000_0000)
			q = 128'h1_0000_0000;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic map_res_t map_point(quad_t f);
		longint px[4], py[4], cf[8];
		longint x0, y0, xi_v, eta_v, dx, de, pe, f0, f1, det;
		longint j00, j01, j10, j11;
		longint unsigned m, adx, ade;
		logic signed [127:0] w00, w01, w10, w11, wf0, wf1;
		int s, n, used;
		bit conv;
		map_res_t r;
		for (int k = 0; k < 4; k++) begin
			px[k] = longint'(signed'(f[2*k]));
			py[k] = longint'(signed'(f[2*k+1]));
		end
		x0 = longint'(signed'(f[8]));
		y0 = longint'(signed'(f[9]));
		for (int k = 0; k < 4; k++) begin
			if (px[k] == x0 && py[k] == y0) begin
				r.xi = (k == 0 || k == 3) ? qibm_pkg::LOC_MONE : qibm_pkg::LOC_ONE;
				r.eta = (k == 0 || k == 1) ? qibm_pkg::LOC_MONE : qibm_pkg::LOC_ONE;
				r.ins = 1'b1;
				r.conv = 1'b1;
				r.iters = '0;
				return r;
			end
		end
		cf[0] = px[0] + px[1] + px[2] + px[3] - 4 * x0;
		cf[1] = -px[0] + px[1] + px[2] - px[3];
		cf[2] = -px[0] - px[1] + px[2] + px[3];
		cf[3] = px[0] - px[1] + px[2] - px[3];
		cf[4] = py[0] + py[1] + py[2] + py[3] - 4 * y0;
		cf[5] = -py[0] + py[1] + py[2] - py[3];
		cf[6] = -py[0] - py[1] + py[2] + py[3];
		cf[7] = py[0] - py[1] + py[2] - py[3];
		m = 0;
		for (int k = 0; k < 8; k++)
			m |= (cf[k] < 0) ? longint'(-cf[k]) : cf[k];
		s = 0;
		while ((m >> s) >= (64'd1 << qibm_pkg::COEF_BITS))
			s++;
		for (int k = 0; k < 8; k++)
			cf[k] = cf[k] >>> s;
		n = (maxit_q > qibm_pkg::ITER_CAP) ? qibm_pkg::ITER_CAP : maxit_q;
		xi_v = 0;
		eta_v = 0;
		used = 0;
		conv = 1'b0;
		while (used < n) begin
			j00 = cf[1] + ((cf[3] * eta_v) >>> qibm_pkg::LOC_FRAC);
			j01 = cf[2] + ((cf[3] * xi_v) >>> qibm_pkg::LOC_FRAC);
			j10 = cf[5] + ((cf[7] * eta_v) >>> qibm_pkg::LOC_FRAC);
			j11 = cf[6] + ((cf[7] * xi_v) >>> qibm_pkg::LOC_FRAC);
			pe = (xi_v * eta_v) >>> qibm_pkg::LOC_FRAC;
			f0 = (cf[0] <<< qibm_pkg::LOC_FRAC) + cf[1] * xi_v + cf[2] * eta_v + cf[3] * pe;
			f1 = (cf[4] <<< qibm_pkg::LOC_FRAC) + cf[5] * xi_v + cf[6] * eta_v + cf[7] * pe;
			det = j00 * j11 - j01 * j10;
			used++;
			if (det == 0)
				break;
			w00 = j00; w01 = j01; w10 = j10; w11 = j11; wf0 = f0; wf1 = f1;
			dx = step_quot(w01 * wf1 - w11 * wf0, det);
			de = step_quot(w10 * wf0 - w00 * wf1, det);
			adx = (dx < 0) ? longint'(-dx) : dx;
			ade = (de < 0) ? longint'(-de) : de;
			if (adx < tol_q && ade < tol_q) begin
				conv = 1'b1;
				break;
			end
			xi_v = xi_v + dx;
			eta_v = eta_v + de;
			if (xi_v > 64'sh7fff_ffff) xi_v = 64'sh7fff_ffff;
			if (xi_v < -64'sh8000_0000) xi_v = -64'sh8000_0000;
			if (eta_v > 64'sh7fff_ffff) eta_v = 64'sh7fff_ffff;
			if (eta_v < -64'sh8000_0000) eta_v = -64'sh8000_0000;
		end
		r.xi = xi_v[31:0];
		r.eta = eta_v[31:0];
		r.ins = (xi_v >= -(64'sd1 << qibm_pkg::LOC_FRAC) && xi_v <= (64'sd1 << qibm_pkg::LOC_FRAC)
			&& eta_v >= -(64'sd1 << qibm_pkg::LOC_FRAC)
			&& eta_v <= (64'sd1 << qibm_pkg::LOC_FRAC));
		r.conv = conv;
		r.iters = 7'(used);
		return r;
	endfunction

	function automatic quad_t square_at(logic signed [31:0] x, logic signed [31:0] y);
		return {y, x, U, -U, U, U, -U, U, -U, -U};
	endfunction

	function automatic map_res_t fixed_res(logic signed [31:0] x, logic signed [31:0] y,
			logic ins, logic cv, logic [6:0] it);
		map_res_t r;
		r.xi = x; r.eta = y; r.ins = ins; r.conv = cv; r.iters = it;
		return r;
	endfunction

	function automatic quad_t random_quad(bit para);
		longint bx, by, sz, q;
		longint cx[4], cy[4];
		quad_t f;
		bx = longint'($signed($urandom_range(0, 32'h0200_0000))) - 64'h0100_0000;
		by = longint'($signed($urandom_range(0, 32'h0200_0000))) - 64'h0100_0000;
		sz = 64'd1 << $urandom_range(6, 20);
		q = sz / 3 + 1;
		cx[0] = bx - sz; cy[0] = by - sz;
		cx[1] = bx + sz; cy[1] = by - sz;
		cx[2] = bx + sz; cy[2] = by + sz;
		cx[3] = bx - sz; cy[3] = by + sz;
		for (int k = 0; k < 4; k++) begin
			cx[k] += longint'($urandom_range(0, 2 * q)) - q;
			cy[k] += longint'($urandom_range(0, 2 * q)) - q;
		end
		if (para) begin
			cx[2] = cx[1] + cx[3] - cx[0];
			cy[2] = cy[1] + cy[3] - cy[0];
		end
		for (int k = 0; k < 4; k++) begin
			f[2*k] = cx[k][31:0];
			f[2*k+1] = cy[k][31:0];
		end
		f[8] = 32'(bx + longint'($urandom_range(0, 3 * sz)) - (3 * sz) / 2);
		f[9] = 32'(by + longint'($urandom_range(0, 3 * sz)) - (3 * sz) / 2);
		return f;
	endfunction

	function automatic quad_t random_item(bit para_only);
		quad_t f;
		int pick, k;
		pick = para_only ? 99 : $urandom_range(0, 99);
		if (pick < 10) begin
			for (int i = 0; i < 10; i++)
				f[i] = $urandom;
		end else if (pick < 15) begin
			f[0] = $urandom; f[1] = $urandom;
			for (int i = 1; i < 4; i++) begin
				f[2*i] = f[0]; f[2*i+1] = f[1];
			end
			f[8] = $urandom; f[9] = $urandom;
		end else if (pick < 25) begin
			f = random_quad(1'b0);
			k = $urandom_range(0, 3);
			f[8] = f[2*k]; f[9] = f[2*k+1];
		end else begin
			f = random_quad(pick >= 90);
		end
		return f;
	endfunction

	task automatic set_config(logic [qibm_pkg::TOL_W-1:0] tol, logic [6:0] maxit);
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= qibm_pkg::CFG_TOLERANCE;
		cfg_data <= tol;
		@(posedge clk);
		cfg_index <= qibm_pkg::CFG_MAX_ITER;
		cfg_data <= {22'($urandom), maxit};
		@(posedge clk);
		cfg_index <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B;
		cfg_data <= 29'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		tol_q = tol;
		maxit_q = maxit;
	endtask

	task automatic send_item(quad_t f, bit typed, map_res_t res);
		map_res_t r;
		r = typed ? res : map_point(f);
		corner0_x <= f[0]; corner0_y <= f[1];
		corner1_x <= f[2]; corner1_y <= f[3];
		corner2_x <= f[4]; corner2_y <= f[5];
		corner3_x <= f[6]; corner3_y <= f[7];
		point_x <= f[8]; point_y <= f[9];
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		pending_q.push_back(r);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n || quiet) begin
			out_stall <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
		end else begin
			out_stall <= ($urandom_range(0, 1) == 0);
			stall_cnt <= $urandom_range(0, 8);
		end
	end

	always @(posedge clk) begin
		map_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected transfer xi=%h eta=%h", $time, xi, eta);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (xi !== e.xi) begin
					$display("%0t: xi exp %h got %h", $time, e.xi, xi);
					errors++;
				end
				if (eta !== e.eta) begin
					$display("%0t: eta exp %h got %h", $time, e.eta, eta);
					errors++;
				end
				if (inside_res !== e.ins) begin
					$display("%0t: inside_res exp %b got %b", $time, e.ins, inside_res);
					errors++;
				end
				if (converged !== e.conv) begin
					$display("%0t: converged exp %b got %b", $time, e.conv, converged);
					errors++;
				end
				if (iterations_used !== e.iters) begin
					$display("%0t: iterations_used exp %0d got %0d", $time, e.iters,
						iterations_used);
					errors++;
				end
			end
		end
	end

	function automatic vec_t row(logic [qibm_pkg::TOL_W-1:0] tol, logic [6:0] maxit, quad_t f,
			bit typed, map_res_t res);
		vec_t v;
		v.tol = tol; v.maxit = maxit; v.f = f; v.typed = typed; v.res = res;
		return v;
	endfunction

	initial begin
		quad_t f;
		map_res_t none;
		map_res_t singular;
		logic signed [31:0] mone;
		logic signed [31:0] one;
		logic [qibm_pkg::TOL_W-1:0] tol;
		logic [6:0] maxit;
		int cnt;
		none = '0;
		mone = qibm_pkg::LOC_MONE;
		one = qibm_pkg::LOC_ONE;
		singular = fixed_res(32'sd0, 32'sd0, 1'b1, 1'b0, 7'd1);

		dir_tab.push_back(row(1, 100, square_at(-U, -U), 1, fixed_res(mone, mone, 1, 1, 0)));
		dir_tab.push_back(row(1, 100, square_at(U, -U), 1, fixed_res(one, mone, 1, 1, 0)));
		dir_tab.push_back(row(1, 100, square_at(U, U), 1, fixed_res(one, one, 1, 1, 0)));
		dir_tab.push_back(row(1, 100, square_at(-U, U), 1, fixed_res(mone, one, 1, 1, 0)));
		// repeated corner: first match wins
		dir_tab.push_back(row(1, 100, {U, U, U, -U, U, U, -U, U, U, U}, 1,
			fixed_res(mone, mone, 1, 1, 0)));
		dir_tab.push_back(row(1, 100, {32'sd0, U, 256'd0}, 1, singular));
		dir_tab.push_back(row(1, 100, {SMIN, SMIN, {8{SMAX}}}, 1, singular));
		dir_tab.push_back(row(1, 100, {SMAX, SMAX, {8{SMIN}}}, 1, singular));
		dir_tab.push_back(row(1, 100, square_at(0, 0), 0, none));
		dir_tab.push_back(row(1, 100, square_at(U / 2, U / 4), 0, none));
		dir_tab.push_back(row(1, 100, square_at(3 * U, 0), 0, none));
		dir_tab.push_back(row(1, 100, {32'sd0, 32'sd0, SMAX, SMIN, SMAX, SMAX, SMIN, SMAX, SMIN,
			SMIN}, 0, none));
		dir_tab.push_back(row(1, 100, {SMAX, SMAX, SMAX, SMIN, SMAX, SMAX, SMIN, SMAX, SMIN,
			SMIN}, 1, fixed_res(one, one, 1, 1, 0)));
		// a quad with three collinear corners, then a square in reversed corner order
		dir_tab.push_back(row(1, 100, {U / 3, U / 5, 2 * U, U / 2, 3 * U, U, -2 * U, 0, -U, -U},
			0, none));
		dir_tab.push_back(row(1, 100, {0, 0, -U, U, U, U, U, -U, -U, -U}, 0, none));
		dir_tab.push_back(row(1, 100, {32'hffff_ffff, 32'hffff_ffff, 32'h1234_5678, 32'h4000_0000,
			32'h7000_0000, 32'h0000_0001, 32'h9abc_def0, 32'h8000_0001, 32'h0fed_cba9, 32'h5a5a_a5a5},
			0, none));
		dir_tab.push_back(row(1, 0, square_at(U / 2, U / 4), 1,
			fixed_res(32'sd0, 32'sd0, 1, 0, 0)));
		dir_tab.push_back(row(0, 3, square_at(U / 2, U / 4), 0, none));
		dir_tab.push_back(row(0, 3, {U / 7, U / 9, 2 * U, U / 2, 3 * U, U, -2 * U, 0, -U, -U},
			0, none));
		dir_tab.push_back(row(29'h1000_0000, 1, square_at(U / 3, -U / 5), 0, none));
		dir_tab.push_back(row(29'h1000_0000, 1, square_at(5 * U, U), 0, none));
		dir_tab.push_back(row(29'h1_0000, 127, {U / 2, U / 3, 3 * U, 2 * U, 3 * U, 0, -U, U, -3 * U,
			-U}, 0, none));
		dir_tab.push_back(row(29'h1_0000, 101, square_at(-U / 3, U / 8), 0, none));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].tol != tol_q || dir_tab[i].maxit != maxit_q) begin
				in_valid <= 1'b0;
				set_config(dir_tab[i].tol, dir_tab[i].maxit);
			end
			send_item(dir_tab[i].f, dir_tab[i].typed, dir_tab[i].res);
		end
		in_valid <= 1'b0;

		for (int p = 0; p < 10; p++) begin
			cnt = 130;
			case (p)
				0: begin tol = 0; maxit = 2; end
				1: begin tol = 29'h1000_0000; maxit = 1; end
				2: begin tol = 1; maxit = 4; end
				3: begin tol = $urandom_range(0, 32'h000f_ffff); maxit = 3; end
				4: begin tol = 29'h1_0000; maxit = $urandom_range(101, 127); cnt = 40; end
				5: begin tol = $urandom_range(0, 32'h1000_0000); maxit = 0; end
				default: begin
					tol = $urandom_range(0, 32'h1000_0000);
					maxit = $urandom_range(1, 4);
				end
			endcase
			set_config(tol, maxit);
			quiet = (p == 9);
			for (int i = 0; i < cnt; i++) begin
				f = random_item(p == 4);
				send_item(f, 1'b0, none);
			end
			in_valid <= 1'b0;
		end

		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule : tb_quad_inverse_bilinear_map_top

[sim.f]
hdl/qibm_pkg.sv
hdl/qibm_mul.sv
hdl/qibm_div.sv
hdl/quad_inverse_bilinear_map_top.sv
tb/sv/tb_quad_inverse_bilinear_map_top.sv
